### rtl/core/aging_state_table_round_robin_defines.svh
// ----------------------------------------------------------------------------
// Aging state table assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AGING_STATE_TABLE_ROUND_ROBIN_DEFINES_SVH
`define AGING_STATE_TABLE_ROUND_ROBIN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASTRR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASTRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/astrr_pkg.sv
// ----------------------------------------------------------------------------
// Aging state table package
// Field widths, operation codes, controller states and shared types.
// ----------------------------------------------------------------------------
package astrr_pkg;

  localparam int ID_W   = 8;
  localparam int LT_W   = 16;
  localparam int TICK_W = 32;
  localparam int SLOT_W = 3;
  localparam int ENT_W  = ID_W + LT_W;

  localparam logic [LT_W-1:0] LIFETIME_RESET = 16'd60;
  localparam logic [LT_W-1:0] LIFETIME_BOUND = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_STORE  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEXT   = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FIN   = 5'b01000,
    S_PREAD = 5'b10000
  } state_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_status_t;

endpackage

### rtl/core/astrr_mod.sv
// ----------------------------------------------------------------------------
// Aging state table tick divider
// Divisibility test of the tick number by a constant: a reciprocal multiply
// gives the quotient, which is multiplied back and compared with the tick
// number. The start pulse moves through stg1, stg2 and done before the status is ready.
// ----------------------------------------------------------------------------
module astrr_mod
  import astrr_pkg::*;
#(
  parameter int DIVISOR = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TICK_W-1:0] dividend,
  output mod_status_t       status
);

  localparam int SH = $clog2(DIVISOR);
  localparam int MW = TICK_W + 1;
  localparam int PW = TICK_W + MW;
  localparam int QW = MW - SH;
  localparam logic [MW-1:0] MAGIC = MW'(((64'd1 << (TICK_W + SH)) / DIVISOR) + 1);

  logic [TICK_W-1:0] x_q;
  logic [TICK_W-1:0] x_d;
  logic [QW-1:0]     quo;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     back;
  logic              stg1;
  logic              stg2;
  logic              done;
  logic              zero;

  assign prod = PW'(x_q) * PW'(MAGIC);
  assign back = PW'(quo) * PW'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg1 <= 1'b0;
      stg2 <= 1'b0;
      done <= 1'b0;
    end else begin
      stg1 <= start;
      stg2 <= stg1;
      done <= stg2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q <= dividend;
    end
    if (stg1) begin
      x_d <= x_q;
      quo <= prod[PW-1 -: QW];
    end
    if (stg2) begin
      zero <= (back == PW'(x_d));
    end
  end

  assign status.done = done;
  assign status.zero = zero;

endmodule

### rtl/core/aging_state_table_round_robin.sv
// ----------------------------------------------------------------------------
// Aging state table with round-robin pick
// Table of ids, lifetimes and payloads in block memories, walked per command.
// ----------------------------------------------------------------------------
//  Channel   Signals                                      Handshake
//  command   start, op, stone_id, payload_in, tick_number  start && !busy
//  result    done, found, slot, picked_id, payload_out     done, one cycle
//  config    cfg_we, cfg_wdata                             cfg_we
//
// Store and remove return their result after one walk over the table memory,
// one entry per cycle; next, when it finds a live entry, adds a payload read
// after the walk. A tick first runs the reciprocal divisibility test, then
// walks the table only on an interval boundary. Reset is synchronous and
// empties the table at once. The receiver cannot stall; a new command may
// start while done is high.
// ----------------------------------------------------------------------------
`include "aging_state_table_round_robin_defines.svh"

module aging_state_table_round_robin
  import astrr_pkg::*;
#(
  parameter int ENTRIES            = 8,
  parameter int PAYLOAD_WIDTH      = 64,
  parameter int TICKS_PER_INTERVAL = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               op,
  input  logic [ID_W-1:0]          stone_id,
  input  logic [PAYLOAD_WIDTH-1:0] payload_in,
  input  logic [TICK_W-1:0]        tick_number,
  input  logic                     cfg_we,
  input  logic [LT_W-1:0]          cfg_wdata,
  output logic                     done,
  output logic                     found,
  output logic [SLOT_W-1:0]        slot,
  output logic [ID_W-1:0]          picked_id,
  output logic [PAYLOAD_WIDTH-1:0] payload_out
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [ENT_W-1:0]         tab_mem [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [ENTRIES];
  logic [ENTRIES-1:0]       tab_vld;
  logic [ENT_W-1:0]         tab_rdata;
  logic                     rd_vld;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata;

  state_t                   state;
  op_t                      op_q;
  logic [ID_W-1:0]          id_q;
  logic [PAYLOAD_WIDTH-1:0] payload_q;
  logic [LT_W-1:0]          lifetime_start;
  logic [IW-1:0]            ptr;
  logic [CW-1:0]            rd_cnt;
  logic                     rd_pend;
  logic [IW-1:0]            rd_addr;
  logic                     hit;
  logic [IW-1:0]            hit_idx;
  logic [ID_W-1:0]          hit_id;
  logic [LT_W-1:0]          min_lt;
  logic [IW-1:0]            min_idx;

  logic                     accept;
  logic                     issue;
  logic                     scan_end;
  logic [IW:0]              raddr_sum;
  logic [IW-1:0]            tab_raddr;
  logic [IW-1:0]            base;
  logic [ID_W-1:0]          ent_id;
  logic [LT_W-1:0]          ent_lt;
  logic [IW-1:0]            st_idx;
  logic                     tab_we;
  logic [IW-1:0]            tab_waddr;
  logic [ENT_W-1:0]         tab_wdata;
  logic                     pay_we;
  mod_status_t              mod_st;

  astrr_mod #(
    .DIVISOR(TICKS_PER_INTERVAL)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && (op_t'(op) == OP_TICK)),
    .dividend(tick_number),
    .status  (mod_st)
  );

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign issue    = (state == S_SCAN) && (rd_cnt != CW'(ENTRIES));
  assign scan_end = (state == S_SCAN) && (rd_cnt == CW'(ENTRIES)) && !rd_pend;
  assign base     = (op_q == OP_NEXT) ? ptr : '0;

  always_comb begin
    raddr_sum = (IW+1)'(base) + (IW+1)'(rd_cnt);
    if (raddr_sum >= (IW+1)'(ENTRIES)) begin
      raddr_sum = raddr_sum - (IW+1)'(ENTRIES);
    end
    tab_raddr = raddr_sum[IW-1:0];
  end

  assign ent_id = rd_vld ? tab_rdata[ENT_W-1:LT_W] : '0;
  assign ent_lt = rd_vld ? tab_rdata[LT_W-1:0] : '0;
  assign st_idx = hit ? hit_idx : min_idx;

  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = rd_addr;
    tab_wdata = {ent_id, LT_W'(ent_lt - LT_W'(1))};
    pay_we    = 1'b0;
    if (rd_pend && (op_q == OP_TICK) && (ent_lt != '0)) begin
      tab_we = 1'b1;
    end else if ((state == S_FIN) && (op_q == OP_STORE)) begin
      tab_we    = 1'b1;
      pay_we    = 1'b1;
      tab_waddr = st_idx;
      tab_wdata = {id_q, lifetime_start};
    end else if ((state == S_FIN) && (op_q == OP_REMOVE) && hit) begin
      tab_we    = 1'b1;
      tab_waddr = hit_idx;
      tab_wdata = {id_q, LT_W'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    tab_rdata <= tab_mem[tab_raddr];
    rd_vld    <= tab_vld[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[tab_waddr] <= payload_q;
    end
    pay_rdata <= pay_mem[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_vld <= '0;
    end else if (tab_we) begin
      tab_vld[tab_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      lifetime_start <= LIFETIME_RESET;
      ptr            <= '0;
      rd_cnt         <= '0;
      rd_pend        <= 1'b0;
      hit            <= 1'b0;
      done           <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= issue;
      if (cfg_we) begin
        lifetime_start <= cfg_wdata;
      end
      if (issue) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (rd_pend && !hit) begin
        if (((op_q == OP_STORE) || (op_q == OP_REMOVE)) && (ent_id == id_q)) begin
          hit <= 1'b1;
        end else if ((op_q == OP_NEXT) && (ent_lt != '0)) begin
          hit <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_cnt <= '0;
            hit    <= 1'b0;
            state  <= (op_t'(op) == OP_TICK) ? S_MOD : S_SCAN;
          end
        end
        S_MOD: begin
          if (mod_st.done) begin
            state <= mod_st.zero ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if ((op_q == OP_NEXT) && hit) begin
            ptr   <= (hit_idx == IW'(ENTRIES - 1)) ? '0 : hit_idx + IW'(1);
            state <= S_PREAD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PREAD: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= tab_raddr;
    if (accept) begin
      op_q      <= op_t'(op);
      id_q      <= stone_id;
      payload_q <= payload_in;
      min_lt    <= LIFETIME_BOUND;
      min_idx   <= '0;
    end
    if (rd_pend) begin
      if ((op_q == OP_STORE) && (ent_lt < min_lt)) begin
        min_lt  <= ent_lt;
        min_idx <= rd_addr;
      end
      if (!hit) begin
        if (((op_q == OP_STORE) || (op_q == OP_REMOVE)) && (ent_id == id_q)) begin
          hit_idx <= rd_addr;
        end else if ((op_q == OP_NEXT) && (ent_lt != '0)) begin
          hit_idx <= rd_addr;
          hit_id  <= ent_id;
        end
      end
    end
    if (state == S_FIN) begin
      found       <= hit;
      slot        <= (op_q == OP_STORE) ? SLOT_W'(st_idx) : (hit ? SLOT_W'(hit_idx) : '0);
      picked_id   <= ((op_q == OP_NEXT) && hit) ? hit_id : '0;
      payload_out <= '0;
    end
    if (state == S_PREAD) begin
      payload_out <= pay_rdata;
    end
  end

  `ASTRR_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a command in flight")
  `ASTRR_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted command did not raise busy")
  `ASTRR_ASSERT_SAME(a_ptr_range, 1'b1, ptr < IW'(ENTRIES - 1) || ptr == IW'(ENTRIES - 1),
                     "scan pointer beyond the table")
  `ASTRR_ASSERT_SAME(a_rd_cnt_range, 1'b1, rd_cnt <= CW'(ENTRIES), "read counter overran")
  `ASTRR_ASSERT_SAME(a_wr_idle, tab_we, busy, "table written while idle")

endmodule

### tb/aging_table_checker.sv
// ----------------------------------------------------------------------------
// Aging state table checker
// Watches the command, config and result channels, keeps its own copy of the
// table and compares every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module aging_table_checker
  import astrr_pkg::*;
#(
  parameter int ENTRIES            = 8,
  parameter int PAYLOAD_WIDTH      = 64,
  parameter int TICKS_PER_INTERVAL = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     busy,
  input  logic [1:0]               op,
  input  logic [ID_W-1:0]          stone_id,
  input  logic [PAYLOAD_WIDTH-1:0] payload_in,
  input  logic [TICK_W-1:0]        tick_number,
  input  logic                     cfg_we,
  input  logic [LT_W-1:0]          cfg_wdata,
  input  logic                     done,
  input  logic                     found,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [ID_W-1:0]          picked_id,
  input  logic [PAYLOAD_WIDTH-1:0] payload_out,
  output int                       mismatches,
  output int                       expect_pending
);

  typedef struct packed {
    logic                     found;
    logic [SLOT_W-1:0]        slot;
    logic [ID_W-1:0]          picked_id;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } table_result_t;

  logic [ID_W-1:0]          tbl_id   [ENTRIES];
  logic [LT_W-1:0]          tbl_life [ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] tbl_data [ENTRIES];
  logic [LT_W-1:0]          life_start;
  int                       scan_ptr;
  int                       error_total;
  table_result_t            predicted_results [$];

  initial begin
    error_total = 0;
  end

  function automatic table_result_t predict_table_op(op_t cmd, logic [ID_W-1:0] id,
                                                     logic [PAYLOAD_WIDTH-1:0] data,
                                                     logic [TICK_W-1:0] tick);
    table_result_t   res;
    int              hit;
    int              pick;
    int              idx;
    int              i;
    logic [LT_W-1:0] lowest;
    res = '0;
    hit = -1;
    for (i = ENTRIES - 1; i >= 0; i--) begin
      if (tbl_id[i] == id) hit = i;
    end
    case (cmd)
      OP_STORE: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          pick = hit;
        end else begin
          pick = 0;
          lowest = LIFETIME_BOUND;
          for (i = 0; i < ENTRIES; i++) begin
            if (tbl_life[i] < lowest) begin
              lowest = tbl_life[i];
              pick = i;
            end
          end
        end
        tbl_id[pick]   = id;
        tbl_life[pick] = life_start;
        tbl_data[pick] = data;
        res.slot = SLOT_W'(pick);
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          tbl_life[hit] = '0;
          res.found = 1'b1;
          res.slot = SLOT_W'(hit);
        end
      end
      OP_NEXT: begin
        for (i = 0; i < ENTRIES; i++) begin
          idx = (scan_ptr + i) % ENTRIES;
          if (!res.found && tbl_life[idx] != 0) begin
            scan_ptr = (idx + 1) % ENTRIES;
            res.found = 1'b1;
            res.slot = SLOT_W'(idx);
            res.picked_id = tbl_id[idx];
            res.payload = tbl_data[idx];
          end
        end
      end
      OP_TICK: begin
        if (tick % TICK_W'(TICKS_PER_INTERVAL) == 0) begin
          for (i = 0; i < ENTRIES; i++) begin
            if (tbl_life[i] != 0) tbl_life[i] = tbl_life[i] - 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tbl_id[i]   = '0;
        tbl_life[i] = '0;
        tbl_data[i] = '0;
      end
      life_start = LIFETIME_RESET;
      scan_ptr = 0;
      predicted_results.delete();
    end else begin
      if (done) begin
        got.found     = found;
        got.slot      = slot;
        got.picked_id = picked_id;
        got.payload   = payload_out;
        if (predicted_results.size() == 0) begin
          error_total++;
          if (error_total <= 10)
            $display("%0t: result beat with nothing expected: found=%0d slot=%0d id=%0h",
                     $realtime, found, slot, picked_id);
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            error_total++;
            if (error_total <= 10) begin
              $display("%0t: result mismatch: expected found=%0d slot=%0d id=%0h payload=%h",
                       $realtime, want.found, want.slot, want.picked_id, want.payload);
              $display("%0t: result mismatch: got      found=%0d slot=%0d id=%0h payload=%h",
                       $realtime, got.found, got.slot, got.picked_id, got.payload);
            end
          end
        end
      end
      if (cfg_we) life_start = cfg_wdata;
      if (start && !busy)
        predicted_results.push_back(predict_table_op(op_t'(op), stone_id, payload_in,
                                                      tick_number));
    end
    expect_pending <= predicted_results.size();
    mismatches <= error_total;
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Aging state table testbench
// Drives directed and random store, remove, next and tick commands under
// several lifetime settings and sender idle rates; a checker beside the block
// predicts every result beat and counts mismatches for the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import astrr_pkg::*;

  localparam int ENTRIES            = 8;
  localparam int PAYLOAD_W          = 64;
  localparam int TICK_INTERVAL      = 10;
  localparam int CYCLE_LIMIT        = 500000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           op;
  logic [ID_W-1:0]      stone_id;
  logic [PAYLOAD_W-1:0] payload_in;
  logic [TICK_W-1:0]    tick_number;
  logic                 cfg_we;
  logic [LT_W-1:0]      cfg_wdata;
  logic                 done;
  logic                 found;
  logic [SLOT_W-1:0]    slot;
  logic [ID_W-1:0]      picked_id;
  logic [PAYLOAD_W-1:0] payload_out;
  int                   mismatches;
  int                   expect_pending;
  int                   cycle_count = 0;

  aging_state_table_round_robin #(
    .ENTRIES(ENTRIES),
    .PAYLOAD_WIDTH(PAYLOAD_W),
    .TICKS_PER_INTERVAL(TICK_INTERVAL)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .stone_id(stone_id), .payload_in(payload_in), .tick_number(tick_number),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .found(found),
    .slot(slot), .picked_id(picked_id), .payload_out(payload_out)
  );

  aging_table_checker #(
    .ENTRIES(ENTRIES),
    .PAYLOAD_WIDTH(PAYLOAD_W),
    .TICKS_PER_INTERVAL(TICK_INTERVAL)
  ) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .stone_id(stone_id), .payload_in(payload_in), .tick_number(tick_number),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done), .found(found),
    .slot(slot), .picked_id(picked_id), .payload_out(payload_out),
    .mismatches(mismatches), .expect_pending(expect_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic issue_command(op_t cmd, logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] data,
                               logic [TICK_W-1:0] tick, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    op          <= cmd;
    stone_id    <= id;
    payload_in  <= data;
    tick_number <= tick;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_table_quiet();
    do @(posedge clk); while (expect_pending != 0 || busy);
  endtask

  task automatic write_lifetime(logic [LT_W-1:0] value);
    start <= 1'b0;
    wait_table_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_command(int unsigned idle_pct);
    int unsigned       roll;
    op_t               cmd;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] tick;
    roll = $urandom_range(0, 99);
    if (roll < 35) cmd = OP_STORE;
    else if (roll < 50) cmd = OP_REMOVE;
    else if (roll < 80) cmd = OP_NEXT;
    else cmd = OP_TICK;
    if ($urandom_range(0, 99) < 80) id = ID_W'($urandom_range(0, 9));
    else id = ID_W'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 1)
      tick = TICK_W'(TICK_INTERVAL) * TICK_W'($urandom_range(0, 32'hFFFFFFFF / TICK_INTERVAL));
    else
      tick = $urandom;
    issue_command(cmd, id, {$urandom, $urandom}, tick, idle_pct);
  endtask

  task automatic run_phase(logic [LT_W-1:0] lifetime, int unsigned idle_pct, int items);
    write_lifetime(lifetime);
    repeat (items) random_command(idle_pct);
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_STORE;
    stone_id    <= '0;
    payload_in  <= '0;
    tick_number <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset lifetime: empty table, id zero matching unwritten entries, removes.
    issue_command(OP_NEXT, 8'h00, '0, '0, 0);
    issue_command(OP_REMOVE, 8'h05, '0, '0, 0);
    issue_command(OP_STORE, 8'h00, '1, '0, 0);
    issue_command(OP_STORE, 8'hFF, '0, '0, 0);
    issue_command(OP_STORE, 8'hAA, 64'h5555_5555_5555_5555, '1, 0);
    issue_command(OP_NEXT, 8'h00, '0, '0, 0);
    issue_command(OP_NEXT, 8'h00, '0, '0, 0);
    issue_command(OP_TICK, 8'h00, '0, 32'd0, 0);
    issue_command(OP_TICK, 8'h00, '0, 32'hFFFF_FFFF, 0);
    issue_command(OP_TICK, 8'h00, '0, 32'd4294967290, 0);
    issue_command(OP_REMOVE, 8'hFF, '0, '0, 0);
    issue_command(OP_REMOVE, 8'hFF, '0, '0, 0);
    issue_command(OP_NEXT, 8'h00, '0, '0, 0);
    issue_command(OP_NEXT, 8'h00, '0, '0, 0);

    // A zero lifetime stores an entry that is already expired.
    write_lifetime(16'h0000);
    issue_command(OP_STORE, 8'h33, 64'hA5A5_0F0F_F0F0_5A5A, '0, 0);
    issue_command(OP_NEXT, 8'h00, '0, '0, 0);

    // Fill the table at the top lifetime, then store with every count at the bound.
    write_lifetime(16'hFFFF);
    for (int i = 0; i < ENTRIES; i++)
      issue_command(OP_STORE, ID_W'(8'h11 + i), {$urandom, $urandom}, '0, 0);
    issue_command(OP_STORE, 8'h77, {$urandom, $urandom}, '0, 0);

    run_phase(16'd3, 0, 200);
    run_phase(16'd1, 75, 150);
    run_phase(16'd65534, 6, 150);
    run_phase(16'hFFFF, 0, 100);
    run_phase(16'd0, 6, 50);
    run_phase(16'd12, 75, 200);
    run_phase(16'd5, 6, 200);

    start <= 1'b0;
    wait_table_quiet();
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expect_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
